@@ design/ilst_pkg.sv @@
package ilst_pkg;

  localparam int CAPACITY = 64;
  localparam int CNT_W    = 7;
  localparam int ACT_W    = 3;
  localparam int DATA_W   = 32;
  localparam int STAT_W   = 2;
  localparam int GRP      = 8;
  localparam int NGRP     = (CAPACITY + GRP - 1) / GRP;

  typedef enum logic [ACT_W-1:0] {
    ACT_READ      = 3'd0,
    ACT_INS_HEAD  = 3'd1,
    ACT_INS_TAIL  = 3'd2,
    ACT_INS_AT    = 3'd3,
    ACT_DELETE    = 3'd4
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_DONE  = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_GATHER
  } state_t;

  typedef struct packed {
    logic              ins;
    logic              del;
    logic              rd;
    logic [CNT_W-1:0]  pos;
    logic [DATA_W-1:0] value;
  } cell_cmd_t;

endpackage

@@ design/ilst_in_if.sv @@
interface ilst_in_if;
  import ilst_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [ACT_W-1:0]         action;
  logic [CNT_W-1:0]         position;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output action, output position, output value, input ready);
  modport sink   (input valid, input action, input position, input value, output ready);
endinterface

@@ design/ilst_out_if.sv @@
interface ilst_out_if;
  import ilst_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] read_value;
  logic [STAT_W-1:0]        status;
  logic [CNT_W-1:0]         length;

  modport source (output valid, output read_value, output status, output length, input ready);
  modport sink   (input valid, input read_value, input status, input length, output ready);
endinterface

@@ design/ilst_cell.sv @@
module ilst_cell
  import ilst_pkg::*;
(
  input  logic              clk,
  input  logic [CNT_W-1:0]  idx,
  input  cell_cmd_t         cmd,
  input  logic [DATA_W-1:0] prev_data,
  input  logic [DATA_W-1:0] next_data,
  output logic [DATA_W-1:0] data,
  output logic [DATA_W-1:0] rd_data
);

  logic hit;
  logic above;

  assign hit     = (idx == cmd.pos);
  assign above   = (idx > cmd.pos);
  assign rd_data = (cmd.rd && hit) ? data : '0;

  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      if (hit) begin
        data <= cmd.value;
      end else if (above) begin
        data <= prev_data;
      end
    end else if (cmd.del) begin
      if (hit || above) begin
        data <= next_data;
      end
    end
  end

endmodule

@@ design/ilst_gather.sv @@
module ilst_gather
  import ilst_pkg::*;
(
  input  logic              clk,
  input  logic [DATA_W-1:0] words [CAPACITY],
  output logic [DATA_W-1:0] word
);

  logic [DATA_W-1:0] grp_or [NGRP];
  logic [DATA_W-1:0] grp_or_next [NGRP];

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_or_next[g] = '0;
      for (int k = 0; k < GRP; k++) begin
        if (g * GRP + k < CAPACITY) begin
          grp_or_next[g] = grp_or_next[g] | words[g * GRP + k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    grp_or <= grp_or_next;
  end

  always_comb begin
    word = '0;
    for (int g = 0; g < NGRP; g++) begin
      word = word | grp_or[g];
    end
  end

endmodule

@@ design/indexed_list_insert_delete_top.sv @@
// Ordered list of up to 64 signed 32-bit values held in a row of cells. Each request
// reads, inserts (head, tail or before a position; position equal to length appends)
// or deletes one entry (other action codes change nothing and report done) and
// returns one response with the read value (zero unless a read succeeds), a status
// (done, out of range, full) and the length after the action. A request goes from
// acceptance to its response in the output register by capture, then a step in
// which the cells at and above the position shift or load at once, then one to finish
// the registered OR tree that picks the read value, waiting while a response is held.
// One request is in flight at a time; a new one is taken once the last has reached
// the output register, and a waiting response does not block capturing the next one.
module indexed_list_insert_delete_top
  import ilst_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  ilst_in_if.sink           req,
  ilst_out_if.source        rsp
);

  state_t            state;
  state_t            state_next;

  logic [ACT_W-1:0]  cmd_action;
  logic [CNT_W-1:0]  cmd_pos;
  logic [DATA_W-1:0] cmd_value;

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;

  status_t           pend_status;
  status_t           exec_status;

  cell_cmd_t         cell_cmd;
  logic              full;

  logic [DATA_W-1:0] cell_data [CAPACITY];
  logic [DATA_W-1:0] cell_rd   [CAPACITY];
  logic [DATA_W-1:0] rd_word;

  logic              out_free;
  logic              req_take;

  assign full     = (count == CNT_W'(CAPACITY));
  assign out_free = !rsp.valid || rsp.ready;
  assign req_take = req.valid && req.ready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_GATHER;
      end
      ST_GATHER: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // outputs and command decode
  always_comb begin
    req.ready      = (state == ST_IDLE) && !rst;
    cell_cmd       = '0;
    cell_cmd.value = cmd_value;
    cell_cmd.pos   = cmd_pos;
    exec_status    = STAT_DONE;
    count_next     = count;
    if (state == ST_EXEC) begin
      case (action_t'(cmd_action))
        ACT_READ: begin
          if (cmd_pos >= count) begin
            exec_status = STAT_RANGE;
          end else begin
            cell_cmd.rd = 1'b1;
          end
        end
        ACT_INS_HEAD: begin
          cell_cmd.pos = '0;
          if (full) begin
            exec_status = STAT_FULL;
          end else begin
            cell_cmd.ins = 1'b1;
          end
        end
        ACT_INS_TAIL: begin
          cell_cmd.pos = count;
          if (full) begin
            exec_status = STAT_FULL;
          end else begin
            cell_cmd.ins = 1'b1;
          end
        end
        ACT_INS_AT: begin
          if (cmd_pos > count) begin
            exec_status = STAT_RANGE;
          end else if (full) begin
            exec_status = STAT_FULL;
          end else begin
            cell_cmd.ins = 1'b1;
          end
        end
        ACT_DELETE: begin
          if (cmd_pos >= count) begin
            exec_status = STAT_RANGE;
          end else begin
            cell_cmd.del = 1'b1;
          end
        end
        default: begin
          exec_status = STAT_DONE;
        end
      endcase
      if (cell_cmd.ins) begin
        count_next = count + CNT_W'(1);
      end else if (cell_cmd.del) begin
        count_next = count - CNT_W'(1);
      end
    end
    // keep the read selected while the response waits
    if (state == ST_GATHER && action_t'(cmd_action) == ACT_READ && cmd_pos < count) begin
      cell_cmd.rd = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (state == ST_GATHER && out_free) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      cmd_action <= req.action;
      cmd_pos    <= req.position;
      cmd_value  <= req.value;
    end
    if (state == ST_EXEC) begin
      pend_status <= exec_status;
    end
    if (state == ST_GATHER && out_free) begin
      rsp.read_value <= rd_word;
      rsp.status     <= pend_status;
      rsp.length     <= count;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] prev_data;
    logic [DATA_W-1:0] next_data;

    if (i == 0) begin : g_first
      assign prev_data = '0;
    end else begin : g_mid_lo
      assign prev_data = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_data = cell_data[i];
    end else begin : g_mid_hi
      assign next_data = cell_data[i+1];
    end

    ilst_cell u_cell (
      .clk       (clk),
      .idx       (CNT_W'(i)),
      .cmd       (cell_cmd),
      .prev_data (prev_data),
      .next_data (next_data),
      .data      (cell_data[i]),
      .rd_data   (cell_rd[i])
    );
  end

  ilst_gather u_gather (
    .clk   (clk),
    .words (cell_rd),
    .word  (rd_word)
  );

endmodule

@@ sim/indexed_list_insert_delete_top_tb.sv @@
module indexed_list_insert_delete_top_tb;
  import ilst_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam int POS_MAX = (1 << CNT_W) - 1;
  localparam int ACT_MAX = (1 << ACT_W) - 1;

  typedef struct packed {
    logic [DATA_W-1:0] read_value;
    status_t           status;
    logic [CNT_W-1:0]  length;
  } list_rsp_t;

  logic clk = 1'b0;
  logic rst;
  logic hold_on = 1'b0;
  event hold_go;

  int snd_idle_pct = 0;
  int rcv_stall_pct = 0;
  int err_cnt = 0;
  int unsigned cycle_cnt = 0;

  logic [DATA_W-1:0] shadow_list[$];
  list_rsp_t         list_rsp_q[$];
  list_rsp_t         want_rsp;

  ilst_in_if  req_if ();
  ilst_out_if rsp_if ();

  indexed_list_insert_delete_top i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  always #5 clk = ~clk;

  // list behavior, applied to the shadow copy
  function automatic list_rsp_t apply_list_op(input logic [ACT_W-1:0] act,
                                              input logic [CNT_W-1:0] pos,
                                              input logic [DATA_W-1:0] val);
    list_rsp_t r;
    int n;
    n = shadow_list.size();
    r.read_value = '0;
    r.status = STAT_DONE;
    case (act)
      ACT_READ: begin
        if (pos >= n) r.status = STAT_RANGE;
        else r.read_value = shadow_list[pos];
      end
      ACT_INS_HEAD: begin
        if (n >= CAPACITY) r.status = STAT_FULL;
        else shadow_list.push_front(val);
      end
      ACT_INS_TAIL: begin
        if (n >= CAPACITY) r.status = STAT_FULL;
        else shadow_list.push_back(val);
      end
      ACT_INS_AT: begin
        if (pos > n) r.status = STAT_RANGE;
        else if (n >= CAPACITY) r.status = STAT_FULL;
        else shadow_list.insert(pos, val);
      end
      ACT_DELETE: begin
        if (pos >= n) r.status = STAT_RANGE;
        else shadow_list.delete(pos);
      end
      default: ;
    endcase
    r.length = CNT_W'(shadow_list.size());
    return r;
  endfunction

  task automatic send_list_op(input logic [ACT_W-1:0] act, input logic [CNT_W-1:0] pos,
                              input logic [DATA_W-1:0] val);
    while ($urandom_range(99) < snd_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.action <= act;
    req_if.position <= pos;
    req_if.value <= val;
    do @(posedge clk); while (!req_if.ready);
    list_rsp_q.push_back(apply_list_op(act, pos, val));
  endtask

  task automatic test_list_edges();
    logic [DATA_W-1:0] min_val;
    logic [DATA_W-1:0] max_val;
    int i;
    min_val = {1'b1, {(DATA_W-1){1'b0}}};
    max_val = {1'b0, {(DATA_W-1){1'b1}}};
    snd_idle_pct <= 0;
    rcv_stall_pct <= 0;
    // empty list
    send_list_op(ACT_READ, 0, $urandom);
    send_list_op(ACT_DELETE, 0, $urandom);
    send_list_op(ACT_INS_AT, 1, $urandom);
    send_list_op(ACT_W'(ACT_DELETE + 1), CNT_W'($urandom_range(POS_MAX)), $urandom);
    send_list_op(ACT_INS_AT, 0, 32'd5);
    send_list_op(ACT_INS_HEAD, CNT_W'($urandom_range(POS_MAX)), min_val);
    send_list_op(ACT_INS_TAIL, CNT_W'($urandom_range(POS_MAX)), max_val);
    send_list_op(ACT_INS_AT, 3, '0);
    send_list_op(ACT_INS_AT, 2, '1);
    for (i = 0; i <= 5; i++) send_list_op(ACT_READ, CNT_W'(i), $urandom);
    send_list_op(ACT_READ, CNT_W'(POS_MAX), $urandom);
    send_list_op(ACT_INS_AT, CNT_W'(POS_MAX), $urandom);
    send_list_op(ACT_DELETE, CNT_W'(POS_MAX), $urandom);
    send_list_op(ACT_W'(ACT_DELETE + 2), 0, '0);
    send_list_op(ACT_W'(ACT_MAX), CNT_W'(POS_MAX), '1);
    send_list_op(ACT_DELETE, 0, $urandom);
    send_list_op(ACT_DELETE, 3, $urandom);
    send_list_op(ACT_DELETE, 1, $urandom);
    send_list_op(ACT_READ, 0, $urandom);
    send_list_op(ACT_READ, 1, $urandom);
  endtask

  // grows toward full and shrinks toward empty in long runs
  task automatic test_random_ops(input int n_ops, input int idle_pct, input int stall_pct);
    int i;
    int len;
    bit grow;
    logic [ACT_W-1:0] act;
    logic [CNT_W-1:0] pos;
    logic [DATA_W-1:0] val;
    snd_idle_pct <= idle_pct;
    rcv_stall_pct <= stall_pct;
    grow = shadow_list.size() < CAPACITY / 2;
    for (i = 0; i < n_ops; i++) begin
      len = shadow_list.size();
      if (len == CAPACITY && $urandom_range(7) == 0) grow = 1'b0;
      else if (len == 0 && $urandom_range(7) == 0) grow = 1'b1;
      if ($urandom_range(99) < 5) act = ACT_W'($urandom_range(ACT_MAX, ACT_DELETE + 1));
      else if ($urandom_range(99) < 20) act = ACT_READ;
      else if ($urandom_range(99) < (grow ? 80 : 20))
        act = ACT_W'($urandom_range(ACT_INS_AT, ACT_INS_HEAD));
      else act = ACT_DELETE;
      if ($urandom_range(99) < 15) pos = CNT_W'($urandom_range(POS_MAX));
      else pos = CNT_W'($urandom_range(len));
      case ($urandom_range(15))
        0: val = {1'b1, {(DATA_W-1){1'b0}}};
        1: val = {1'b0, {(DATA_W-1){1'b1}}};
        2: val = '0;
        3: val = '1;
        default: val = $urandom;
      endcase
      send_list_op(act, pos, val);
    end
  endtask

  task automatic test_output_holdoff();
    -> hold_go;
    test_random_ops(40, 0, 0);
  endtask

  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      rsp_if.ready <= !hold_on && ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  initial begin
    forever begin
      @(hold_go);
      hold_on <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_on <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (list_rsp_q.size() == 0) begin
        $display("%0t: unexpected item read_value=%0d status=%0d length=%0d", $time,
                 $signed(rsp_if.read_value), rsp_if.status, rsp_if.length);
        err_cnt++;
      end else begin
        want_rsp = list_rsp_q.pop_front();
        if (rsp_if.read_value !== want_rsp.read_value) begin
          $display("%0t: read_value expected %0d actual %0d", $time,
                   $signed(want_rsp.read_value), $signed(rsp_if.read_value));
          err_cnt++;
        end
        if (rsp_if.status !== want_rsp.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want_rsp.status,
                   rsp_if.status);
          err_cnt++;
        end
        if (rsp_if.length !== want_rsp.length) begin
          $display("%0t: length expected %0d actual %0d", $time, want_rsp.length,
                   rsp_if.length);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout with %0d items outstanding", list_rsp_q.size());
      $display("indexed_list_insert_delete_top_tb: FAIL");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    req_if.valid = 1'b0;
    req_if.action = ACT_READ;
    req_if.position = '0;
    req_if.value = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_list_edges();
    test_random_ops(300, 0, 0);
    test_random_ops(250, 81, 0);
    test_random_ops(250, 0, 81);
    test_random_ops(300, 36, 36);
    test_output_holdoff();
    test_random_ops(60, 36, 36);

    req_if.valid <= 1'b0;
    rcv_stall_pct <= 0;
    while (list_rsp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("indexed_list_insert_delete_top_tb: PASS");
    end else begin
      $display("indexed_list_insert_delete_top_tb: FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/ilst_pkg.sv
design/ilst_in_if.sv
design/ilst_out_if.sv
design/ilst_cell.sv
design/ilst_gather.sv
design/indexed_list_insert_delete_top.sv
sim/indexed_list_insert_delete_top_tb.sv
